// ===== rtl/core/rrp_pkg.sv =====
// Shared types, limits and character codes for the RESP request parser.
package rrp_pkg;

  // Accumulator width: large enough for the biggest integer value.
  localparam int ACC_W = 63;
  // Element counter width, fixed by the element index field.
  localparam int ELEM_W = 16;

  // Protocol limits.
  localparam longint unsigned MAX_ELEMENTS    = 64'd65535;
  localparam longint unsigned MAX_BULK_LENGTH = 64'd262143;
  localparam int LEN_W = $clog2(MAX_BULK_LENGTH + 64'd1);

  localparam logic [ACC_W-1:0] LIMIT_COUNT = ACC_W'(MAX_ELEMENTS);
  localparam logic [ACC_W-1:0] LIMIT_LEN   = ACC_W'(MAX_BULK_LENGTH);
  localparam logic [ACC_W-1:0] LIMIT_INT   = {ACC_W{1'b1}};

  // Character codes.
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // Result event codes.
  localparam logic [2:0] EV_COUNT = 3'd0;
  localparam logic [2:0] EV_BYTE  = 3'd1;
  localparam logic [2:0] EV_SEND  = 3'd2;
  localparam logic [2:0] EV_INT   = 3'd3;
  localparam logic [2:0] EV_ERR   = 3'd4;

  // One input transaction.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic [2:0]        event_res;
    logic [ACC_W-1:0]  value;
    logic [ELEM_W-1:0] element_index;
    logic              frame_last;
  } out_item_t;

  // Result from the parser core to the output register.
  typedef struct packed {
    logic      load;
    out_item_t item;
  } res_t;

endpackage

// ===== rtl/core/resp_request_parser_top.sv =====
// Top level of the RESP request parser: input register, parser core, output register.
//
//  channel | direction | payload            | handshake
//  in_     | input     | in_item_t          | in_valid / in_stall
//  out_    | output    | out_item_t         | out_valid / out_stall
//
// One byte is accepted per cycle while in_stall is low; each byte yields zero or one event.
// A byte is registered in the input register while the parser decodes it,
// and its event is then registered in the output register.
// in_stall comes from the skid entry flop, so the two sides share no comb path.
// rst_n is synchronous and active low; it returns the parser to waiting for '*'.
module resp_request_parser_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rrp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rrp_pkg::out_item_t out_data
);
  import rrp_pkg::*;

  logic     item_valid;
  in_item_t item;
  logic     item_take;
  logic     res_ready;
  res_t     res;

  rrp_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  rrp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_ready  (res_ready),
    .res        (res)
  );

  rrp_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/rrp_in_stage.sv =====
// Input register with a skid entry so that in_stall comes straight from a flop.
module rrp_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rrp_pkg::in_item_t in_data,
  output logic              item_valid,
  output rrp_pkg::in_item_t item,
  input  logic              item_take
);
  import rrp_pkg::*;

  logic     main_vld_r, main_vld_nxt;
  logic     skid_vld_r, skid_vld_nxt;
  in_item_t main_r, main_nxt;
  in_item_t skid_r, skid_nxt;
  logic     accept;

  assign in_stall   = skid_vld_r;
  assign accept     = in_valid && !skid_vld_r;
  assign item_valid = main_vld_r;
  assign item       = main_r;

  // Main entry feeds the parser; the skid entry catches a transaction that
  // arrives while the main entry is held.
  always_comb begin
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    if (item_take) begin
      if (skid_vld_r) begin
        main_nxt     = skid_r;
        skid_vld_nxt = 1'b0;
      end else begin
        main_vld_nxt = accept;
        main_nxt     = in_data;
      end
    end else if (!main_vld_r) begin
      main_vld_nxt = accept;
      main_nxt     = in_data;
    end else if (accept) begin
      skid_vld_nxt = 1'b1;
      skid_nxt     = in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  // The skid entry is only ever occupied behind a full main entry.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> main_vld_r)
    else $error("skid entry full while main entry empty");

  // The parser never takes from an empty main entry.
  a_take_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    item_take |-> main_vld_r)
    else $error("take from empty input register");

endmodule

// ===== rtl/core/rrp_core.sv =====
// Parser FSM: decodes a byte per cycle while res_ready, into at most one event.
module rrp_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  rrp_pkg::in_item_t item,
  output logic              item_take,
  input  logic              res_ready,
  output rrp_pkg::res_t     res
);
  import rrp_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_COUNT    = 4'd1,
    PH_COUNT_LF = 4'd2,
    PH_LEAD     = 4'd3,
    PH_LEN      = 4'd4,
    PH_LEN_LF   = 4'd5,
    PH_DATA     = 4'd6,
    PH_TRAIL    = 4'd7,
    PH_INT      = 4'd8,
    PH_INT_LF   = 4'd9,
    PH_DROP     = 4'd10
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [ELEM_W-1:0] left_r, left_nxt;
  logic [ELEM_W-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0]  pay_r, pay_nxt;
  logic [1:0]        skip_r, skip_nxt;

  logic [ACC_W-1:0]  limit;
  logic [ACC_W+3:0]  prod;
  logic [3:0]        dig_val;
  logic              is_digit;
  logic              digit_ok;

  logic              emit, err, done, elem_done, dropping;
  logic [2:0]        ev;
  logic [ACC_W-1:0]  val;
  logic              last;
  logic [ELEM_W-1:0] idx;
  logic [7:0]        b;
  logic              last_byte;

  assign b         = item.data_byte;
  assign last_byte = item.buffer_end;
  assign item_take = item_valid && res_ready;

  // Decimal digit unit: acc * 10 + digit, checked against the field's limit.
  always_comb begin
    case (phase_r)
      PH_COUNT: limit = LIMIT_COUNT;
      PH_LEN:   limit = LIMIT_LEN;
      default:  limit = LIMIT_INT;
    endcase
    is_digit = b inside {[CH_ZERO:CH_NINE]};
    dig_val  = 4'(b - CH_ZERO);
    prod     = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + (ACC_W+4)'(dig_val);
    digit_ok = is_digit && (prod <= {4'b0, limit});
  end

  // Next state and event for the byte in the input register.
  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    left_nxt  = left_r;
    pos_nxt   = pos_r;
    pay_nxt   = pay_r;
    skip_nxt  = skip_r;
    emit      = 1'b0;
    err       = 1'b0;
    done      = 1'b0;
    elem_done = 1'b0;
    dropping  = 1'b0;
    ev        = EV_COUNT;
    val       = '0;
    last      = 1'b0;
    idx       = pos_r;

    case (phase_r)
      PH_IDLE: begin
        if (b == CH_STAR) begin
          acc_nxt   = '0;
          left_nxt  = '0;
          pos_nxt   = '0;
          pay_nxt   = '0;
          skip_nxt  = '0;
          idx       = '0;
          phase_nxt = PH_COUNT;
        end else begin
          err = 1'b1;
        end
      end
      PH_COUNT: begin
        if (b == CH_CR) begin
          if (acc_r == '0) begin
            err = 1'b1;
          end else begin
            left_nxt  = acc_r[ELEM_W-1:0];
            emit      = 1'b1;
            ev        = EV_COUNT;
            val       = acc_r;
            idx       = '0;
            acc_nxt   = '0;
            phase_nxt = PH_COUNT_LF;
          end
        end else if (digit_ok) begin
          acc_nxt = prod[ACC_W-1:0];
        end else begin
          err = 1'b1;
        end
      end
      PH_COUNT_LF: begin
        phase_nxt = PH_LEAD;
      end
      PH_LEAD: begin
        acc_nxt = '0;
        if (b == CH_DOLLAR) begin
          phase_nxt = PH_LEN;
        end else if (b == CH_COLON) begin
          phase_nxt = PH_INT;
        end else begin
          err = 1'b1;
        end
      end
      PH_LEN: begin
        if (b == CH_CR) begin
          phase_nxt = PH_LEN_LF;
        end else if (digit_ok) begin
          acc_nxt = prod[ACC_W-1:0];
        end else begin
          err = 1'b1;
        end
      end
      PH_LEN_LF: begin
        pay_nxt = acc_r[LEN_W-1:0];
        acc_nxt = '0;
        if (acc_r[LEN_W-1:0] != '0) begin
          phase_nxt = PH_DATA;
        end else begin
          skip_nxt  = 2'd2;
          phase_nxt = PH_TRAIL;
        end
      end
      PH_DATA: begin
        emit    = 1'b1;
        ev      = EV_BYTE;
        val     = ACC_W'(b);
        pay_nxt = pay_r - LEN_W'(1);
        if (pay_r == LEN_W'(1)) begin
          skip_nxt  = 2'd2;
          phase_nxt = PH_TRAIL;
        end
      end
      PH_TRAIL: begin
        skip_nxt = skip_r - 2'd1;
        if (skip_r == 2'd1) begin
          emit      = 1'b1;
          ev        = EV_SEND;
          elem_done = 1'b1;
        end
      end
      PH_INT: begin
        if (b == CH_CR) begin
          phase_nxt = PH_INT_LF;
        end else if (digit_ok) begin
          acc_nxt = prod[ACC_W-1:0];
        end else begin
          err = 1'b1;
        end
      end
      PH_INT_LF: begin
        emit      = 1'b1;
        ev        = EV_INT;
        val       = acc_r;
        acc_nxt   = '0;
        elem_done = 1'b1;
      end
      default: begin
        // Discard the rest of the buffer after an error or a finished frame.
        dropping = 1'b1;
        if (last_byte) begin
          phase_nxt = PH_IDLE;
        end
      end
    endcase

    if (!dropping) begin
      // Element bookkeeping.
      if (elem_done) begin
        left_nxt = left_r - ELEM_W'(1);
        pos_nxt  = pos_r + ELEM_W'(1);
        if (left_r == ELEM_W'(1)) begin
          last = 1'b1;
          done = 1'b1;
        end else begin
          phase_nxt = PH_LEAD;
        end
      end

      // A buffer that ends before the frame is complete is an error.
      if (!err && !done && last_byte) begin
        err = 1'b1;
      end

      if (err) begin
        emit = 1'b1;
        ev   = EV_ERR;
        val  = '0;
        last = 1'b0;
        idx  = pos_nxt;
      end
      if (err || done) begin
        phase_nxt = last_byte ? PH_IDLE : PH_DROP;
      end
    end

    res.load               = item_take && emit;
    res.item.event_res     = ev;
    res.item.value         = val;
    res.item.element_index = idx;
    res.item.frame_last    = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      acc_r   <= '0;
      left_r  <= '0;
      pos_r   <= '0;
      pay_r   <= '0;
      skip_r  <= '0;
    end else if (item_take) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      left_r  <= left_nxt;
      pos_r   <= pos_nxt;
      pay_r   <= pay_nxt;
      skip_r  <= skip_nxt;
    end
  end

  // The last byte of a buffer always leaves the parser waiting for a new frame.
  a_buffer_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    item_take && item.buffer_end |=> phase_r == PH_IDLE)
    else $error("parser not idle after buffer end");

  // Inside a frame's elements at least one element is still outstanding.
  a_elements_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_LEAD || phase_r == PH_LEN || phase_r == PH_LEN_LF ||
     phase_r == PH_DATA || phase_r == PH_TRAIL || phase_r == PH_INT ||
     phase_r == PH_INT_LF) |-> left_r != '0)
    else $error("element phase with no elements left");

  // Only a string end or an integer can close a frame.
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    res.load && res.item.frame_last |->
      (res.item.event_res == EV_SEND || res.item.event_res == EV_INT))
    else $error("frame_last on wrong event");

endmodule

// ===== rtl/core/rrp_out_stage.sv =====
// Output register holding one result transaction until the receiver takes it.
module rrp_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  rrp_pkg::res_t      res,
  output logic               res_ready,
  output logic               out_valid,
  input  logic               out_stall,
  output rrp_pkg::out_item_t out_data
);
  import rrp_pkg::*;

  logic      vld_r, vld_nxt;
  out_item_t data_r, data_nxt;

  // The register can load when it is empty or its transaction leaves this cycle.
  assign res_ready = !vld_r || !out_stall;
  assign out_valid = vld_r;
  assign out_data  = data_r;

  always_comb begin
    vld_nxt  = vld_r && out_stall;
    data_nxt = data_r;
    if (res.load) begin
      vld_nxt  = 1'b1;
      data_nxt = res.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    data_r <= data_nxt;
  end

  // A load never overwrites a transaction that is still stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res.load |-> res_ready)
    else $error("result loaded while output register is held");

endmodule

// ===== bench/resp_request_parser_check.sv =====
`timescale 1ns / 100ps
// Event checker for the RESP request parser: predicts each event from accepted bytes and compares.
module resp_request_parser_check (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  rrp_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  rrp_pkg::out_item_t out_data,
  output int                 mismatch_count,
  output int                 results_pending
);
  import rrp_pkg::*;

  // Parse phases of the request being followed.
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_COUNT,
    PH_COUNT_LF,
    PH_LEAD,
    PH_LEN,
    PH_LEN_LF,
    PH_DATA,
    PH_TRAIL,
    PH_INT,
    PH_INT_LF,
    PH_DROP
  } parse_phase_t;

  parse_phase_t      phase;
  longint unsigned   acc;
  logic [15:0]       elems_left;
  logic [15:0]       elem_pos;
  logic [31:0]       payload_left;
  logic [1:0]        skip_cnt;
  out_item_t         expected_events[$];
  int                errors = 0;

  // Folds one decimal digit into a running number; fails on a non-digit or past the limit.
  function automatic bit fold_digit(input logic [7:0] ch, input longint unsigned limit,
                                    input longint unsigned acc_in,
                                    output longint unsigned acc_out);
    longint unsigned d;
    acc_out = acc_in;
    if (ch < CH_ZERO || ch > CH_NINE) return 1'b0;
    d = 64'(ch - CH_ZERO);
    if (d > limit) return 1'b0;
    if (acc_in > (limit - d) / 10) return 1'b0;
    acc_out = acc_in * 10 + d;
    return 1'b1;
  endfunction

  // Advances the parse state by one byte and works out the event it causes, if any.
  task automatic predict_event(input in_item_t it, output bit fires, output out_item_t res);
    logic [7:0]  ch;
    bit          last_in;
    bit          failed;
    bit          finished;
    bit          elem_end;
    logic [2:0]  code;
    logic [62:0] val;
    logic [15:0] idx;
    bit          fl;
    ch       = it.data_byte;
    last_in  = it.buffer_end;
    fires    = 1'b0;
    failed   = 1'b0;
    finished = 1'b0;
    elem_end = 1'b0;
    code     = EV_COUNT;
    val      = '0;
    fl       = 1'b0;
    idx      = elem_pos;
    res      = '0;

    case (phase)
      PH_IDLE: begin
        if (ch == CH_STAR) begin
          acc          = 0;
          elems_left   = '0;
          elem_pos     = '0;
          payload_left = '0;
          skip_cnt     = '0;
          idx          = '0;
          phase        = PH_COUNT;
        end else begin
          failed = 1'b1;
        end
      end
      PH_COUNT: begin
        if (ch == CH_CR) begin
          if (acc == 0) begin
            failed = 1'b1;
          end else begin
            elems_left = acc[15:0];
            fires      = 1'b1;
            code       = EV_COUNT;
            val        = acc[62:0];
            idx        = '0;
            acc        = 0;
            phase      = PH_COUNT_LF;
          end
        end else if (!fold_digit(ch, MAX_ELEMENTS, acc, acc)) begin
          failed = 1'b1;
        end
      end
      PH_COUNT_LF: phase = PH_LEAD;
      PH_LEAD: begin
        acc = 0;
        if (ch == CH_DOLLAR) phase = PH_LEN;
        else if (ch == CH_COLON) phase = PH_INT;
        else failed = 1'b1;
      end
      PH_LEN: begin
        if (ch == CH_CR) phase = PH_LEN_LF;
        else if (!fold_digit(ch, MAX_BULK_LENGTH, acc, acc)) failed = 1'b1;
      end
      PH_LEN_LF: begin
        payload_left = acc[31:0];
        acc          = 0;
        if (payload_left != 0) begin
          phase = PH_DATA;
        end else begin
          skip_cnt = 2'd2;
          phase    = PH_TRAIL;
        end
      end
      PH_DATA: begin
        fires        = 1'b1;
        code         = EV_BYTE;
        val          = 63'(ch);
        payload_left = payload_left - 1;
        if (payload_left == 0) begin
          skip_cnt = 2'd2;
          phase    = PH_TRAIL;
        end
      end
      PH_TRAIL: begin
        skip_cnt = skip_cnt - 2'd1;
        if (skip_cnt == 0) begin
          fires    = 1'b1;
          code     = EV_SEND;
          elem_end = 1'b1;
        end
      end
      PH_INT: begin
        if (ch == CH_CR) phase = PH_INT_LF;
        else if (!fold_digit(ch, 64'(LIMIT_INT), acc, acc)) failed = 1'b1;
      end
      PH_INT_LF: begin
        fires    = 1'b1;
        code     = EV_INT;
        val      = acc[62:0];
        acc      = 0;
        elem_end = 1'b1;
      end
      default: begin
        // Rest of the buffer after an error or a finished request is dropped.
        if (last_in) phase = PH_IDLE;
        return;
      end
    endcase

    // Close the element and see whether the request is complete.
    if (elem_end) begin
      elems_left = elems_left - 16'd1;
      elem_pos   = elem_pos + 16'd1;
      if (elems_left == 0) begin
        fl       = 1'b1;
        finished = 1'b1;
      end else begin
        phase = PH_LEAD;
      end
    end

    // A buffer that ends before the request does is a protocol error.
    if (!failed && !finished && last_in) failed = 1'b1;

    if (failed) begin
      fires = 1'b1;
      code  = EV_ERR;
      val   = '0;
      fl    = 1'b0;
      idx   = elem_pos;
    end
    if (failed || finished) phase = last_in ? PH_IDLE : PH_DROP;

    res.event_res     = code;
    res.value         = val;
    res.element_index = idx;
    res.frame_last    = fl;
  endtask

  // Predict on each input transaction and compare each output transaction with the oldest event.
  always @(posedge clk) begin : track
    bit        fires;
    out_item_t predicted;
    out_item_t want;
    if (!rst_n) begin
      phase        = PH_IDLE;
      acc          = 0;
      elems_left   = '0;
      elem_pos     = '0;
      payload_left = '0;
      skip_cnt     = '0;
      expected_events.delete();
    end else begin
      if (in_valid && !in_stall) begin
        predict_event(in_data, fires, predicted);
        if (fires) expected_events.push_back(predicted);
      end
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          errors++;
          $error("unexpected result: event_res %0d value %0d element_index %0d frame_last %0d",
                 out_data.event_res, out_data.value, out_data.element_index,
                 out_data.frame_last);
        end else begin
          want = expected_events.pop_front();
          if (out_data.event_res !== want.event_res) begin
            errors++;
            $error("event_res: expected %0d, actual %0d", want.event_res, out_data.event_res);
          end
          if (out_data.value !== want.value) begin
            errors++;
            $error("value: expected %0d, actual %0d", want.value, out_data.value);
          end
          if (out_data.element_index !== want.element_index) begin
            errors++;
            $error("element_index: expected %0d, actual %0d", want.element_index,
                   out_data.element_index);
          end
          if (out_data.frame_last !== want.frame_last) begin
            errors++;
            $error("frame_last: expected %0d, actual %0d", want.frame_last,
                   out_data.frame_last);
          end
        end
      end
    end
    mismatch_count  <= errors;
    results_pending <= expected_events.size();
  end

endmodule

// ===== bench/resp_request_parser_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the RESP request parser: builds request buffers, drives them, gives the verdict.
module resp_request_parser_top_tb;
  import rrp_pkg::*;

  localparam int         RANDOM_ITEMS = 1050;
  localparam int         HOLD_START   = 300;
  localparam int         HOLD_CYCLES  = 160;
  localparam int         DRAIN_CYCLES = 10;
  localparam int         TIMEOUT_NS   = 2_000_000;
  localparam logic [7:0] CH_LF        = 8'h0A;

  // Receiver stall patterns.
  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_SPARSE} rx_mode_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  int        mismatch_count;
  int        results_pending;
  in_item_t  byte_stream[$];

  resp_request_parser_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  resp_request_parser_check result_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .results_pending(results_pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Stream building helpers.
  task automatic add_byte(input logic [7:0] b);
    byte_stream.push_back('{data_byte: b, buffer_end: 1'b0});
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // Decimal digits, now and then with a leading zero.
  task automatic add_number(input longint unsigned v);
    if ($urandom_range(0, 11) == 0) add_byte(CH_ZERO);
    add_text($sformatf("%0d", v));
  endtask

  // CR and a skipped byte, which is usually LF but is never checked.
  task automatic add_line_end();
    add_byte(CH_CR);
    add_byte(($urandom_range(0, 3) == 0) ? 8'($urandom) : CH_LF);
  endtask

  task automatic close_buffer();
    byte_stream[byte_stream.size() - 1].buffer_end = 1'b1;
  endtask

  // One array element: mostly bulk strings and integers, a few bad leads and overflows.
  task automatic add_element();
    int unsigned     pick;
    int unsigned     form;
    int unsigned     body;
    longint unsigned hdr;
    longint unsigned r;
    pick = $urandom_range(0, 99);
    r    = 64'({$urandom, $urandom});
    if (pick < 55) begin
      add_byte(CH_DOLLAR);
      form = $urandom_range(0, 39);
      case (form)
        0:       hdr = MAX_BULK_LENGTH;
        1:       hdr = MAX_BULK_LENGTH + 1 + $urandom_range(0, 5000000);
        2:       hdr = 0;
        3, 4, 5: hdr = $urandom_range(7, 24);
        default: hdr = $urandom_range(0, 6);
      endcase
      // An empty digit string reads as length zero.
      if (form != 2) add_number(hdr);
      add_line_end();
      body = (hdr <= 24) ? int'(hdr) : $urandom_range(0, 8);
      repeat (body) add_byte(8'($urandom));
      add_line_end();
    end else if (pick < 98) begin
      add_byte(CH_COLON);
      case ($urandom_range(0, 31))
        0:       add_number(64'(LIMIT_INT));
        1:       add_text("9223372036854775808");
        2:       add_text("99999999999999999999");
        3:       ;
        4, 5:    add_number(r >> 1);
        6, 7:    add_number(r >> $urandom_range(2, 62));
        default: add_number($urandom_range(0, 999));
      endcase
      add_line_end();
    end else begin
      add_byte(8'($urandom));
      repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
    end
  endtask

  // One read buffer: mostly a well-formed request, the rest noise, damage or cut-offs.
  task automatic add_request();
    int unsigned kind;
    int unsigned elems;
    int unsigned start;
    int unsigned pos;
    start = byte_stream.size();
    kind  = $urandom_range(0, 99);
    if (kind < 5) begin
      repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
      close_buffer();
      return;
    end
    elems = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
    add_byte(CH_STAR);
    if (kind < 8) add_number($urandom_range(65536, 9999999));
    else if (kind == 8) ;
    else if (kind < 11) add_number(0);
    else if (kind < 13) add_number(MAX_ELEMENTS - (kind - 11));
    else add_number(elems);
    add_line_end();
    repeat (elems) add_element();
    if (kind >= 13 && kind < 21) begin
      pos = $urandom_range(start, byte_stream.size() - 1);
      byte_stream[pos].data_byte = 8'($urandom);
    end else if (kind >= 21 && kind < 27 && byte_stream.size() - start > 1) begin
      repeat ($urandom_range(1, byte_stream.size() - start - 1)) void'(byte_stream.pop_back());
    end else if (kind >= 27 && kind < 33) begin
      repeat ($urandom_range(1, 5)) add_byte(8'($urandom));
    end
    close_buffer();
  endtask

  // Short directed buffers covering several error kinds and every event kind.
  task automatic add_directed();
    // Bad first byte.
    add_byte(8'hFF);
    close_buffer();
    // Non-digit in the count.
    add_byte(CH_STAR);
    add_text("a");
    close_buffer();
    // Zero count.
    add_byte(CH_STAR);
    add_text("0");
    add_byte(CH_CR);
    close_buffer();
    // One-byte string, then a byte dropped after the finished request.
    add_byte(CH_STAR);
    add_text("1");
    add_line_end();
    add_byte(CH_DOLLAR);
    add_text("1");
    add_line_end();
    add_byte(8'h00);
    add_line_end();
    add_byte(8'hFF);
    close_buffer();
    // Integer element, then the buffer ends on the next lead.
    add_byte(CH_STAR);
    add_text("2");
    add_line_end();
    add_byte(CH_COLON);
    add_text("9");
    add_line_end();
    add_byte(CH_COLON);
    close_buffer();
  endtask

  // Sender: bursts of transactions with random gaps, then drain and verdict.
  initial begin : sender
    int unsigned pos;
    int unsigned burst;
    int unsigned gap;
    in_valid <= 1'b0;
    in_data  <= '0;
    rst_n    <= 1'b0;
    add_directed();
    pos = byte_stream.size();
    while (byte_stream.size() < pos + RANDOM_ITEMS) add_request();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    pos = 0;
    while (pos < byte_stream.size()) begin
      burst = $urandom_range(1, 48);
      gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      while (burst != 0 && pos < byte_stream.size()) begin
        in_valid <= 1'b1;
        in_data  <= byte_stream[pos];
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pos++;
        burst--;
      end
    end
    in_valid <= 1'b0;
    // Let the checker count the event of the last transaction before waiting on it.
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Receiver: changing stall patterns, with one long hold-off to back the block up.
  initial begin : receiver
    int unsigned cycles;
    int unsigned span;
    rx_mode_t    mode;
    bit          held;
    cycles = 0;
    held   = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (!held && cycles >= HOLD_START) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        cycles += HOLD_CYCLES;
      end
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(4, 40);
      repeat (span) begin
        case (mode)
          RX_FREE:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 4) == 0);
          RX_HEAVY: out_stall <= ($urandom_range(0, 1) == 1);
          default:  out_stall <= (cycles % 4 != 0);
        endcase
        @(posedge clk);
        cycles++;
      end
    end
  end

  // Watchdog for a hung run.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

endmodule
